@@ design/tile_map_box_collision_macros.svh @@
// Assertion macros shared by the tile map collision design.
`ifndef TILE_MAP_BOX_COLLISION_MACROS_SVH
`define TILE_MAP_BOX_COLLISION_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TMBC_ASSERT_IMP(lbl, ck, rn, a, b) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (a) |-> (b)) \
        else $error("tmbc: implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TMBC_ASSERT_NEXT(lbl, ck, rn, a, b) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (a) |=> (b)) \
        else $error("tmbc: next-cycle check failed");

`endif

@@ design/tmbc_pkg.sv @@
// Shared constants, codes and types for the tile map collision block.
package tmbc_pkg;

    localparam int MAP_CELLS_DEF = 4096;
    localparam int MAX_SPAN_DEF  = 16;
    localparam int TILE_BITS_DEF = 4;

    localparam int PIX_W  = 16;  // box edge in pixels, signed
    localparam int CO_W   = 18;  // tile coordinate, signed, with headroom for +-1 and +k
    localparam int MAG_W  = 15;  // magnitude of a box edge
    localparam int TS_W   = 7;
    localparam int MAP_W  = 9;
    localparam int CFG_W  = 9;
    localparam int PROD_W = 26;
    localparam int IDX_W  = 2 * MAP_W + 1;

    localparam int SNAP_LIMIT = 6;
    localparam int CODE_SOLID = 1;
    localparam int CODE_SPIKE = 3;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [1:0] CFG_TILE_SIZE  = 2'd0;
    localparam logic [1:0] CFG_MAP_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_MAP_HEIGHT = 2'd2;

    // Cell select within one scan step
    localparam logic [2:0] SEL_LEFT_COL  = 3'd0;
    localparam logic [2:0] SEL_RIGHT_COL = 3'd1;
    localparam logic [2:0] SEL_OUT_LEFT  = 3'd2;
    localparam logic [2:0] SEL_OUT_RIGHT = 3'd3;
    localparam logic [2:0] SEL_BOTTOM    = 3'd4;
    localparam logic [2:0] SEL_TOP       = 3'd5;
    localparam logic [2:0] SEL_BELOW     = 3'd6;
    localparam logic [2:0] SEL_ABOVE     = 3'd7;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_SCAN,
        ST_DRAIN,
        ST_FIN
    } state_t;

endpackage

@@ design/tmbc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module tmbc_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ design/tmbc_div.sv @@
// Bit-serial floor divider of a signed pixel edge by the tile size.
module tmbc_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [tmbc_pkg::PIX_W-1:0]  dividend,
    input  logic        [tmbc_pkg::TS_W-1:0]   divisor,
    output logic                               done,
    output logic signed [tmbc_pkg::CO_W-1:0]   quot
);

    localparam int MAG_W = tmbc_pkg::MAG_W;
    localparam int TS_W  = tmbc_pkg::TS_W;
    localparam int CO_W  = tmbc_pkg::CO_W;

    logic                     busy_reg;
    logic                     done_reg;
    logic [3:0]               cnt_reg;
    logic [TS_W-1:0]          rem_reg;
    logic [TS_W-1:0]          dsr_reg;
    logic [MAG_W-1:0]         dvd_reg;
    logic [MAG_W-1:0]         quo_reg;
    logic                     neg_reg;
    logic signed [CO_W-1:0]   quot_reg;

    logic [tmbc_pkg::PIX_W-1:0] mag;
    logic [TS_W:0]              trial;
    logic                       ge;
    logic [TS_W-1:0]            rem_next;
    logic [MAG_W-1:0]           quo_next;
    logic signed [CO_W-1:0]     q_pos;
    logic signed [CO_W-1:0]     quot_next;

    always_comb
    begin
        mag      = dividend[tmbc_pkg::PIX_W-1] ? (~dividend + 1'b1) : dividend;
        trial    = {rem_reg, dvd_reg[MAG_W-1]};
        ge       = (trial >= {1'b0, dsr_reg});
        rem_next = ge ? TS_W'(trial - {1'b0, dsr_reg}) : trial[TS_W-1:0];
        quo_next = {quo_reg[MAG_W-2:0], ge};
        q_pos    = $signed(CO_W'(quo_next));
        // floor for negatives: round the magnitude up, then negate
        if (neg_reg)
        begin
            quot_next = -(q_pos + ((rem_next != '0) ? CO_W'(1) : CO_W'(0)));
        end
        else
        begin
            quot_next = q_pos;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'(MAG_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dsr_reg <= divisor;
            dvd_reg <= mag[MAG_W-1:0];
            quo_reg <= '0;
            neg_reg <= dividend[tmbc_pkg::PIX_W-1];
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[MAG_W-2:0], 1'b0};
            quo_reg <= quo_next;
            if (cnt_reg == 4'(MAG_W - 1))
            begin
                quot_reg <= quot_next;
            end
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

@@ design/tile_map_box_collision.sv @@
// Tile map box collision: top level with tile RAM, edge dividers and scan sequencer.
// Tile write: stored when accepted, no result. Query: edge division, then the scan, the
// drain and the result load, in that order; the scan reads one RAM cell per cycle, the
// divider retires one bit a cycle. Input is ready again in the cycle after the result loads.
// One item at a time; a finished result may wait in the output register while the next is taken.
// Reset: async, active low; registers return to 16/64/64 and a clearing pass writes zero to
// every tile entry, during which no item is accepted (config still is).
`include "tile_map_box_collision_macros.svh"

module tile_map_box_collision #(
    parameter int MAP_CELLS = tmbc_pkg::MAP_CELLS_DEF,
    parameter int MAX_SPAN  = tmbc_pkg::MAX_SPAN_DEF,
    parameter int TILE_BITS = tmbc_pkg::TILE_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    // configuration write channel
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [8:0]          cfg_data,
    // input channel
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                op,
    input  logic [11:0]         tile_index,
    input  logic [3:0]          tile_value,
    input  logic [13:0]         pos_x,
    input  logic [13:0]         pos_y,
    input  logic [9:0]          size_x,
    input  logic [9:0]          size_y,
    input  logic signed [9:0]   offset_x,
    input  logic signed [9:0]   offset_y,
    input  logic signed [14:0]  probe_y,
    // result channel
    output logic                out_valid,
    input  logic                out_ready,
    output logic                blocked_left,
    output logic                blocked_right,
    output logic                landed,
    output logic signed [14:0]  landed_y,
    output logic                spike_touch,
    output logic                enemy_left,
    output logic                enemy_right,
    output logic                enemy_down,
    output logic                enemy_up,
    output logic                squeezed_vertical,
    output logic                squeezed_horizontal,
    output logic                on_spikes
);

    localparam int AW     = $clog2(MAP_CELLS);
    localparam int CW     = $clog2(MAX_SPAN) + 3;
    localparam int PIX_W  = tmbc_pkg::PIX_W;
    localparam int CO_W   = tmbc_pkg::CO_W;
    localparam int TS_W   = tmbc_pkg::TS_W;
    localparam int MAP_W  = tmbc_pkg::MAP_W;
    localparam int PROD_W = tmbc_pkg::PROD_W;
    localparam int IDX_W  = tmbc_pkg::IDX_W;

    tmbc_pkg::state_t state_reg, state_next;

    // ---------------- configuration registers ----------------
    logic [TS_W-1:0]  tile_size_reg;
    logic [MAP_W-1:0] map_width_reg;
    logic [MAP_W-1:0] map_height_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tile_size_reg  <= TS_W'(16);
            map_width_reg  <= MAP_W'(64);
            map_height_reg <= MAP_W'(64);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                tmbc_pkg::CFG_TILE_SIZE:  tile_size_reg  <= cfg_data[TS_W-1:0];
                tmbc_pkg::CFG_MAP_WIDTH:  map_width_reg  <= cfg_data;
                tmbc_pkg::CFG_MAP_HEIGHT: map_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // tile size zero behaves as one
    logic [TS_W-1:0] ts_eff;
    assign ts_eff = (tile_size_reg == '0) ? TS_W'(1) : tile_size_reg;

    // ---------------- control ----------------
    logic in_xfer, div_start, div_done, issue, out_load, clr_last, scan_last;
    logic [AW-1:0] clr_cnt_reg;
    logic [CW-1:0] cnt_reg;
    logic          v1_reg, v2_reg;
    logic          out_valid_reg;

    assign in_xfer   = in_valid && in_ready;
    assign clr_last  = (clr_cnt_reg == AW'(MAP_CELLS - 1));
    assign scan_last = (cnt_reg == CW'(MAX_SPAN * 8 - 1));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tmbc_pkg::ST_CLEAR: if (clr_last) state_next = tmbc_pkg::ST_IDLE;
            tmbc_pkg::ST_IDLE:
                if (in_valid && op == tmbc_pkg::OP_QUERY) state_next = tmbc_pkg::ST_DIV;
            tmbc_pkg::ST_DIV:   if (div_done) state_next = tmbc_pkg::ST_SCAN;
            tmbc_pkg::ST_SCAN:  if (scan_last) state_next = tmbc_pkg::ST_DRAIN;
            tmbc_pkg::ST_DRAIN: if (!v1_reg && !v2_reg) state_next = tmbc_pkg::ST_FIN;
            tmbc_pkg::ST_FIN:
                if (!out_valid_reg || out_ready) state_next = tmbc_pkg::ST_IDLE;
            default:            state_next = tmbc_pkg::ST_CLEAR;
        endcase
    end

    always_comb
    begin
        in_ready  = (state_reg == tmbc_pkg::ST_IDLE);
        div_start = in_xfer && (op == tmbc_pkg::OP_QUERY);
        issue     = (state_reg == tmbc_pkg::ST_SCAN);
        out_load  = (state_reg == tmbc_pkg::ST_FIN) && (!out_valid_reg || out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= tmbc_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
            cnt_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == tmbc_pkg::ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (issue)
            begin
                cnt_reg <= scan_last ? '0 : cnt_reg + 1'b1;
            end
        end
    end

    // ---------------- query capture and edge division ----------------
    logic signed [PIX_W-1:0] left_c, right_c, top_c, bottom_c;
    logic signed [CO_W-1:0]  x0, x1, y0, y1;
    logic [9:0]              sy_reg;
    logic signed [14:0]      probe_reg;
    logic                    done_x1, done_y0, done_y1;

    always_comb
    begin
        left_c   = $signed({2'b00, pos_x}) + PIX_W'(offset_x);
        top_c    = $signed({2'b00, pos_y}) + PIX_W'(offset_y);
        right_c  = left_c + $signed({6'b0, size_x}) - PIX_W'(1);
        bottom_c = top_c + $signed({6'b0, size_y}) - PIX_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (div_start)
        begin
            sy_reg    <= size_y;
            probe_reg <= probe_y;
        end
    end

    tmbc_div u_div_x0 (.clk(clk), .rst_n(rst_n), .start(div_start), .dividend(left_c),
                       .divisor(ts_eff), .done(div_done), .quot(x0));
    tmbc_div u_div_x1 (.clk(clk), .rst_n(rst_n), .start(div_start), .dividend(right_c),
                       .divisor(ts_eff), .done(done_x1), .quot(x1));
    tmbc_div u_div_y0 (.clk(clk), .rst_n(rst_n), .start(div_start), .dividend(top_c),
                       .divisor(ts_eff), .done(done_y0), .quot(y0));
    tmbc_div u_div_y1 (.clk(clk), .rst_n(rst_n), .start(div_start), .dividend(bottom_c),
                       .divisor(ts_eff), .done(done_y1), .quot(y1));

    // ---------------- scan: address generation ----------------
    // Step k covers row y0+k of the side columns and column x0+k of the edge rows.
    logic [CW-1:0]          kfull;
    logic signed [CO_W-1:0] koff, r_k, c_k, col_c, row_c;
    logic                   row_act, col_act, act_c;
    logic [2:0]             sel;

    always_comb
    begin
        kfull   = cnt_reg >> 3;
        koff    = $signed(CO_W'(kfull));
        r_k     = y0 + koff;
        c_k     = x0 + koff;
        row_act = (r_k <= y1);
        col_act = (c_k <= x1);
        sel     = cnt_reg[2:0];
        col_c   = x0;
        row_c   = r_k;
        act_c   = row_act;
        case (sel)
            tmbc_pkg::SEL_LEFT_COL:  col_c = x0;
            tmbc_pkg::SEL_RIGHT_COL: col_c = x1;
            tmbc_pkg::SEL_OUT_LEFT:  col_c = x0 - CO_W'(1);
            tmbc_pkg::SEL_OUT_RIGHT: col_c = x1 + CO_W'(1);
            tmbc_pkg::SEL_BOTTOM:    begin col_c = c_k; row_c = y1; act_c = col_act; end
            tmbc_pkg::SEL_TOP:       begin col_c = c_k; row_c = y0; act_c = col_act; end
            tmbc_pkg::SEL_BELOW:
            begin
                col_c = c_k; row_c = y1 + CO_W'(1); act_c = col_act;
            end
            tmbc_pkg::SEL_ABOVE:
            begin
                col_c = c_k; row_c = y0 - CO_W'(1); act_c = col_act;
            end
            default: ;
        endcase
    end

    logic signed [CO_W-1:0] col1_reg, row1_reg;
    logic [2:0]             sel1_reg, sel2_reg;
    logic                   act1_reg, act2_reg, grid2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= issue;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        col1_reg <= col_c;
        row1_reg <= row_c;
        sel1_reg <= sel;
        act1_reg <= act_c;
    end

    // ---------------- scan: grid check and RAM read ----------------
    logic             in_grid;
    logic [IDX_W-1:0] idx;

    always_comb
    begin
        idx = IDX_W'(row1_reg[MAP_W-1:0]) * IDX_W'(map_width_reg)
            + IDX_W'(col1_reg[MAP_W-1:0]);
        in_grid = !col1_reg[CO_W-1] && !row1_reg[CO_W-1]
               && (col1_reg < $signed(CO_W'(map_width_reg)))
               && (row1_reg < $signed(CO_W'(map_height_reg)))
               && (idx < IDX_W'(MAP_CELLS));
    end

    always_ff @(posedge clk)
    begin
        sel2_reg  <= sel1_reg;
        act2_reg  <= act1_reg;
        grid2_reg <= in_grid;
    end

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [TILE_BITS-1:0] ram_wdata, ram_rdata;

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = AW'(tile_index);
        ram_wdata = TILE_BITS'(tile_value);
        if (state_reg == tmbc_pkg::ST_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = '0;
        end
        else if (in_xfer && op == tmbc_pkg::OP_WRITE
                 && ({5'b0, tile_index} < 17'(MAP_CELLS)))
        begin
            ram_we = 1'b1;
        end
    end

    tmbc_ram #(.WIDTH(TILE_BITS), .DEPTH(MAP_CELLS)) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(idx[AW-1:0]),
        .rdata(ram_rdata)
    );

    // ---------------- scan: accumulate ----------------
    logic [TILE_BITS-1:0] tile;
    logic                 nz, solid, spike;
    logic lc_any_reg, lc_solid_reg, rc_any_reg, rc_solid_reg, br_any_reg, br_spike_reg;
    logic tr_any_reg, below_spike_reg, sqv_reg, sqh_reg, pend_reg;

    always_comb
    begin
        tile  = grid2_reg ? ram_rdata : '0;  // off-grid cells read empty
        nz    = (tile != '0);
        solid = (tile == TILE_BITS'(tmbc_pkg::CODE_SOLID));
        spike = (tile == TILE_BITS'(tmbc_pkg::CODE_SPIKE));
    end

    always_ff @(posedge clk)
    begin
        if (div_start)
        begin
            lc_any_reg <= 1'b0; lc_solid_reg <= 1'b0;
            rc_any_reg <= 1'b0; rc_solid_reg <= 1'b0;
            br_any_reg <= 1'b0; br_spike_reg <= 1'b0;
            tr_any_reg <= 1'b0; below_spike_reg <= 1'b0;
            sqv_reg    <= 1'b0; sqh_reg <= 1'b0;
            pend_reg   <= 1'b0;
        end
        else if (v2_reg && act2_reg)
        begin
            case (sel2_reg)
                tmbc_pkg::SEL_LEFT_COL:
                begin
                    lc_any_reg <= lc_any_reg | nz; lc_solid_reg <= lc_solid_reg | solid;
                end
                tmbc_pkg::SEL_RIGHT_COL:
                begin
                    rc_any_reg <= rc_any_reg | nz; rc_solid_reg <= rc_solid_reg | solid;
                end
                tmbc_pkg::SEL_OUT_LEFT:  pend_reg <= nz;
                tmbc_pkg::SEL_OUT_RIGHT: sqh_reg  <= sqh_reg | (pend_reg & nz);
                tmbc_pkg::SEL_BOTTOM:
                begin
                    br_any_reg <= br_any_reg | nz; br_spike_reg <= br_spike_reg | spike;
                end
                tmbc_pkg::SEL_TOP:       tr_any_reg <= tr_any_reg | nz;
                tmbc_pkg::SEL_BELOW:
                begin
                    below_spike_reg <= below_spike_reg | spike;
                    pend_reg        <= nz;
                end
                tmbc_pkg::SEL_ABOVE:     sqv_reg <= sqv_reg | (pend_reg & nz);
                default: ;
            endcase
        end
    end

    // ---------------- landing snap ----------------
    logic signed [PROD_W-1:0] prod_reg, prod_next, diff, ly, sy_ext;
    logic                     landed_c;
    logic signed [14:0]       ly_sat;

    assign prod_next = PROD_W'($signed({1'b0, ts_eff})) * PROD_W'(y1);

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            prod_reg <= prod_next;
        end
    end

    always_comb
    begin
        sy_ext   = $signed(PROD_W'(sy_reg));
        diff     = PROD_W'(probe_reg) - prod_reg + sy_ext;
        landed_c = br_any_reg && (diff <= PROD_W'(tmbc_pkg::SNAP_LIMIT));
        ly       = landed_c ? (prod_reg - sy_ext) : PROD_W'(probe_reg);
        if (ly > PROD_W'(16383))
        begin
            ly_sat = 15'sd16383;
        end
        else if (ly < -PROD_W'(16384))
        begin
            ly_sat = -15'sd16384;
        end
        else
        begin
            ly_sat = ly[14:0];
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            blocked_left        <= lc_solid_reg;
            blocked_right       <= rc_solid_reg;
            landed              <= landed_c;
            landed_y            <= ly_sat;
            spike_touch         <= br_spike_reg;
            enemy_left          <= lc_any_reg;
            enemy_right         <= rc_any_reg;
            enemy_down          <= br_any_reg;
            enemy_up            <= tr_any_reg;
            squeezed_vertical   <= sqv_reg;
            squeezed_horizontal <= sqh_reg;
            on_spikes           <= below_spike_reg;
        end
    end

    assign out_valid = out_valid_reg;

    // ---------------- assertions ----------------
    logic scan_phase, lanes_ok;

    assign scan_phase = (state_reg == tmbc_pkg::ST_SCAN) || (state_reg == tmbc_pkg::ST_DRAIN);
    assign lanes_ok   = done_x1 && done_y0 && done_y1 && (state_reg == tmbc_pkg::ST_DIV);

    `TMBC_ASSERT_IMP(a_no_write_in_scan, clk, rst_n, scan_phase, !ram_we)
    `TMBC_ASSERT_IMP(a_div_lanes_agree, clk, rst_n, div_done, lanes_ok)
    `TMBC_ASSERT_IMP(a_pipe_order, clk, rst_n, v2_reg, $past(v1_reg))
    `TMBC_ASSERT_NEXT(a_load_sets_valid, clk, rst_n, out_load, out_valid_reg)

endmodule

@@ tb/sv/tile_map_box_collision_checker.sv @@
// Checker: mirrors the tile grid, predicts each query result and compares it.
`timescale 1ns / 1ps

module tile_map_box_collision_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [8:0]         cfg_data,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic               op,
    input  logic [11:0]        tile_index,
    input  logic [3:0]         tile_value,
    input  logic [13:0]        pos_x,
    input  logic [13:0]        pos_y,
    input  logic [9:0]         size_x,
    input  logic [9:0]         size_y,
    input  logic signed [9:0]  offset_x,
    input  logic signed [9:0]  offset_y,
    input  logic signed [14:0] probe_y,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic               blocked_left,
    input  logic               blocked_right,
    input  logic               landed,
    input  logic signed [14:0] landed_y,
    input  logic               spike_touch,
    input  logic               enemy_left,
    input  logic               enemy_right,
    input  logic               enemy_down,
    input  logic               enemy_up,
    input  logic               squeezed_vertical,
    input  logic               squeezed_horizontal,
    input  logic               on_spikes,
    output int                 errors,
    output int                 pending
);

    typedef struct packed {
        logic        blk_l;
        logic        blk_r;
        logic        land;
        logic [14:0] land_y;
        logic        spike;
        logic        en_l;
        logic        en_r;
        logic        en_d;
        logic        en_u;
        logic        sq_v;
        logic        sq_h;
        logic        spikes_below;
    } hit_report_t;

    logic [3:0]  grid [tmbc_pkg::MAP_CELLS_DEF];
    logic [6:0]  tile_px;
    logic [8:0]  cols;
    logic [8:0]  rows;
    hit_report_t report_q [$];

    function automatic longint floor_div(longint a, longint d);
        longint q;
        q = a / d;
        if (a % d != 0 && a < 0)
            q--;
        return q;
    endfunction

    function automatic logic [3:0] tile_at(longint c, longint r);
        longint idx;
        if (c < 0 || r < 0 || c >= longint'(cols) || r >= longint'(rows))
            return '0;
        idx = r * longint'(cols) + c;
        if (idx >= tmbc_pkg::MAP_CELLS_DEF)
            return '0;
        return grid[idx];
    endfunction

    // bit0 any nonzero, bit1 solid, bit2 spike; horiz selects row scan
    function automatic logic [2:0] scan(bit horiz, longint fixed, longint a, longint b);
        logic [2:0] r;
        logic [3:0] t;
        r = '0;
        for (int k = 0; k < tmbc_pkg::MAX_SPAN_DEF; k++) begin
            if (a + k > b)
                break;
            t = horiz ? tile_at(a + k, fixed) : tile_at(fixed, a + k);
            if (t != 0) r[0] = 1'b1;
            if (t == tmbc_pkg::CODE_SOLID) r[1] = 1'b1;
            if (t == tmbc_pkg::CODE_SPIKE) r[2] = 1'b1;
        end
        return r;
    endfunction

    function automatic hit_report_t predict_hits();
        hit_report_t h;
        longint ts, sy, lft, tp, x0, x1, y0, y1, ly;
        logic [2:0] lc, rc, br, tr, bl;
        ts  = (tile_px == 0) ? 1 : longint'(tile_px);
        sy  = longint'(size_y);
        lft = longint'(pos_x) + longint'(offset_x);
        tp  = longint'(pos_y) + longint'(offset_y);
        x0 = floor_div(lft, ts);
        x1 = floor_div(lft + longint'(size_x) - 1, ts);
        y0 = floor_div(tp, ts);
        y1 = floor_div(tp + sy - 1, ts);
        lc = scan(1'b0, x0, y0, y1);
        rc = scan(1'b0, x1, y0, y1);
        br = scan(1'b1, y1, x0, x1);
        tr = scan(1'b1, y0, x0, x1);
        bl = scan(1'b1, y1 + 1, x0, x1);
        h.land = br[0] && (longint'(probe_y) - ts * y1 + sy <= tmbc_pkg::SNAP_LIMIT);
        ly = h.land ? ts * y1 - sy : longint'(probe_y);
        if (ly > 16383) ly = 16383;
        if (ly < -16384) ly = -16384;
        h.land_y = ly[14:0];
        h.sq_v = 1'b0;
        h.sq_h = 1'b0;
        for (int k = 0; k < tmbc_pkg::MAX_SPAN_DEF; k++) begin
            if (x0 + k > x1)
                break;
            if (tile_at(x0 + k, y0 - 1) != 0 && tile_at(x0 + k, y1 + 1) != 0)
                h.sq_v = 1'b1;
        end
        for (int k = 0; k < tmbc_pkg::MAX_SPAN_DEF; k++) begin
            if (y0 + k > y1)
                break;
            if (tile_at(x0 - 1, y0 + k) != 0 && tile_at(x1 + 1, y0 + k) != 0)
                h.sq_h = 1'b1;
        end
        h.blk_l = lc[1];
        h.blk_r = rc[1];
        h.spike = br[2];
        h.en_l  = lc[0];
        h.en_r  = rc[0];
        h.en_d  = br[0];
        h.en_u  = tr[0];
        h.spikes_below = bl[2];
        return h;
    endfunction

    function automatic int field_diff(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        hit_report_t w;
        int bad;
        if (!rst_n)
        begin
            for (int i = 0; i < tmbc_pkg::MAP_CELLS_DEF; i++)
                grid[i] = '0;
            tile_px = 7'd16;
            cols    = 9'd64;
            rows    = 9'd64;
            errors  = 0;
            report_q.delete();
            pending = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    tmbc_pkg::CFG_TILE_SIZE:  tile_px = cfg_data[6:0];
                    tmbc_pkg::CFG_MAP_WIDTH:  cols = cfg_data;
                    tmbc_pkg::CFG_MAP_HEIGHT: rows = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                if (op == tmbc_pkg::OP_WRITE)
                    grid[tile_index] = tile_value;
                else
                    report_q.push_back(predict_hits());
            end
            if (out_valid && out_ready)
            begin
                if (report_q.size() == 0)
                begin
                    $error("result transfer with no query outstanding");
                    errors++;
                end
                else
                begin
                    w = report_q.pop_front();
                    bad = 0;
                    bad += field_diff("blocked_left", w.blk_l, blocked_left);
                    bad += field_diff("blocked_right", w.blk_r, blocked_right);
                    bad += field_diff("landed", w.land, landed);
                    bad += field_diff("landed_y", int'($signed(w.land_y)), int'(landed_y));
                    bad += field_diff("spike_touch", w.spike, spike_touch);
                    bad += field_diff("enemy_left", w.en_l, enemy_left);
                    bad += field_diff("enemy_right", w.en_r, enemy_right);
                    bad += field_diff("enemy_down", w.en_d, enemy_down);
                    bad += field_diff("enemy_up", w.en_u, enemy_up);
                    bad += field_diff("squeezed_vertical", w.sq_v, squeezed_vertical);
                    bad += field_diff("squeezed_horizontal", w.sq_h, squeezed_horizontal);
                    bad += field_diff("on_spikes", w.spikes_below, on_spikes);
                    errors += bad;
                end
            end
            pending = report_q.size();
        end
    end

endmodule

@@ tb/sv/testbench.sv @@
// Testbench top: clock, reset, stimulus, result sink and verdict.
`timescale 1ns / 1ps

module testbench;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [1:0]         cfg_index = tmbc_pkg::CFG_TILE_SIZE;
    logic [8:0]         cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               op = tmbc_pkg::OP_WRITE;
    logic [11:0]        tile_index = '0;
    logic [3:0]         tile_value = '0;
    logic [13:0]        pos_x = '0;
    logic [13:0]        pos_y = '0;
    logic [9:0]         size_x = 10'd1;
    logic [9:0]         size_y = 10'd1;
    logic signed [9:0]  offset_x = '0;
    logic signed [9:0]  offset_y = '0;
    logic signed [14:0] probe_y = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic               blocked_left, blocked_right, landed, spike_touch;
    logic signed [14:0] landed_y;
    logic               enemy_left, enemy_right, enemy_down, enemy_up;
    logic               squeezed_vertical, squeezed_horizontal, on_spikes;
    int                 errors;
    int                 pending;

    // Live copy of the settings, used only to aim stimulus at the grid
    int                 cur_ts = 16;
    int                 cur_w = 64;
    int                 cur_h = 64;

    always #4 clk = ~clk;

    tile_map_box_collision u_top (.*);

    tile_map_box_collision_checker u_check (.*);

    // Sends one item on the input channel after a random gap. in_valid is left
    // high afterwards so that back-to-back items never drop it within a step.
    task automatic send_item(logic o, logic [11:0] ti, logic [3:0] tv, logic [13:0] px,
                             logic [13:0] py, logic [9:0] sx, logic [9:0] sy,
                             logic signed [9:0] ox, logic signed [9:0] oy,
                             logic signed [14:0] pr);
        int gap;
        gap = $urandom_range(0, 5);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        op         <= o;
        tile_index <= ti;
        tile_value <= tv;
        pos_x      <= px;
        pos_y      <= py;
        size_x     <= sx;
        size_y     <= sy;
        offset_x   <= ox;
        offset_y   <= oy;
        probe_y    <= pr;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic put_tile(int c, int r, logic [3:0] v);
        send_item(tmbc_pkg::OP_WRITE, 12'((r * cur_w + c) % 4096), v, '0, '0, 10'd1, 10'd1,
                  '0, '0, '0);
    endtask

    // Waits for the result queue to empty, then for the block to settle.
    task automatic wait_quiet();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (200) @(posedge clk);
    endtask

    // Writes all three registers; block must already be idle.
    task automatic set_map(logic [8:0] ts, logic [8:0] w, logic [8:0] h);
        logic [8:0] vals [3];
        vals = '{ts, w, h};
        for (int i = 0; i < 3; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= 2'(i);
            cfg_data  <= vals[i];
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        cur_ts = (ts[6:0] == 0) ? 1 : int'(ts[6:0]);
        cur_w  = (w == 0) ? 1 : int'(w);
        cur_h  = (h == 0) ? 1 : int'(h);
    endtask

    // Random query aimed at the populated corner of the grid, with a probe near
    // the landing line so that snaps happen; one in eight is unconstrained.
    task automatic random_query();
        int lft, tp, sx, sy, ox, oy, px, py, bot, pr;
        if ($urandom_range(0, 7) == 0)
        begin
            send_item(tmbc_pkg::OP_QUERY, 12'($urandom), 4'($urandom), 14'($urandom),
                      14'($urandom), 10'($urandom_range(1, 1023)),
                      10'($urandom_range(1, 1023)), 10'($urandom), 10'($urandom),
                      15'($urandom));
            return;
        end
        sx = $urandom_range(1, 3 * cur_ts);
        sy = $urandom_range(1, 3 * cur_ts);
        if (sx > 1023) sx = 1023;
        if (sy > 1023) sy = 1023;
        ox = $urandom_range(0, 2 * cur_ts) - cur_ts;
        oy = $urandom_range(0, 2 * cur_ts) - cur_ts;
        if (ox > 511) ox = 511;
        if (oy > 511) oy = 511;
        if (ox < -512) ox = -512;
        if (oy < -512) oy = -512;
        lft = $urandom_range(0, 20) * cur_ts + $urandom_range(0, cur_ts - 1) - cur_ts;
        tp  = $urandom_range(0, 20) * cur_ts + $urandom_range(0, cur_ts - 1) - cur_ts;
        px = lft - ox;
        py = tp - oy;
        if (px < 0) px = 0;
        if (py < 0) py = 0;
        if (px > 16383) px = 16383;
        if (py > 16383) py = 16383;
        bot = py + oy + sy - 1;
        pr = (bot >= 0 ? bot / cur_ts : -1) * cur_ts - sy + $urandom_range(0, 16) - 8;
        send_item(tmbc_pkg::OP_QUERY, 12'($urandom), 4'($urandom), 14'(px), 14'(py),
                  10'(sx), 10'(sy), 10'(ox), 10'(oy), 15'(pr));
    endtask

    // Result sink: random stall before each result.
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            stall = $urandom_range(0, 5);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
        end
    end

    initial
    begin
        logic [8:0] phase_cfg [6][3];
        logic [3:0] v;
        phase_cfg = '{'{9'd16, 9'd64, 9'd64}, '{9'h180, 9'd511, 9'd1},
                      '{9'd1, 9'd256, 9'd256}, '{9'd64, 9'd16, 9'd16},
                      '{9'h1FF, 9'd511, 9'd511}, '{9'd7, 9'd100, 9'd40}};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at reset settings: a solid cross and spikes around tile (1,1)
        put_tile(1, 0, 4'd1);
        put_tile(1, 2, 4'd3);
        put_tile(0, 1, 4'd1);
        put_tile(2, 1, 4'd1);
        put_tile(0, 0, 4'd3);
        put_tile(63, 63, 4'd15);
        // box exactly on tile (1,1): squeezes both ways, spikes below
        send_item(tmbc_pkg::OP_QUERY, '0, '0, 14'd16, 14'd16, 10'd16, 10'd16, '0, '0, 15'd0);
        // one pixel box in the spike corner, probe extremes
        send_item(tmbc_pkg::OP_QUERY, '0, '0, 14'd0, 14'd0, 10'd1, 10'd1, '0, '0,
                  -15'sd16384);
        send_item(tmbc_pkg::OP_QUERY, '0, '0, 14'd0, 14'd0, 10'd1, 10'd1, '0, '0,
                  15'sd16383);
        // negative pixels land left of and above the grid
        send_item(tmbc_pkg::OP_QUERY, '0, '0, 14'd0, 14'd0, 10'd20, 10'd20, -10'sd512,
                  -10'sd512, 15'd0);
        send_item(tmbc_pkg::OP_QUERY, '0, '0, 14'd0, 14'd0, 10'd600, 10'd600, -10'sd512,
                  -10'sd512, 15'd0);
        // far corner, beyond the grid
        send_item(tmbc_pkg::OP_QUERY, '0, '0, 14'h3FFF, 14'h3FFF, 10'd1023, 10'd1023,
                  10'sd511, 10'sd511, 15'd0);
        // long edges wider than the scan span
        send_item(tmbc_pkg::OP_QUERY, '0, '0, 14'd0, 14'd0, 10'd1023, 10'd1023, '0, '0,
                  15'd500);
        // landing check on the solid tile at (1,0), probes outside the snap window
        send_item(tmbc_pkg::OP_QUERY, '0, '0, 14'd18, 14'd4, 10'd8, 10'd10, '0, '0, 15'sd6);
        send_item(tmbc_pkg::OP_QUERY, '0, '0, 14'd18, 14'd4, 10'd8, 10'd10, '0, '0, 15'sd7);
        put_tile(63, 63, 4'd0);
        send_item(tmbc_pkg::OP_QUERY, '0, '0, 14'd1008, 14'd1008, 10'd16, 10'd16, '0, '0,
                  15'd0);

        for (int p = 0; p < 6; p++)
        begin
            wait_quiet();
            set_map(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2]);
            for (int n = 0; n < 90; n++)
            begin
                // one mid-phase hold-off until every result is back
                if (p == 1 && n == 40)
                    wait_quiet();
                if (n < 25 || $urandom_range(0, 2) == 0)
                begin
                    case ($urandom_range(0, 3))
                        0: v = 4'd0;
                        1: v = 4'(tmbc_pkg::CODE_SOLID);
                        2: v = 4'(tmbc_pkg::CODE_SPIKE);
                        default: v = 4'($urandom);
                    endcase
                    if ($urandom_range(0, 9) == 0)
                        send_item(tmbc_pkg::OP_WRITE, 12'($urandom), v, 14'($urandom),
                                  14'($urandom), 10'($urandom), 10'($urandom),
                                  10'($urandom), 10'($urandom), 15'($urandom));
                    else
                        put_tile($urandom_range(0, 20), $urandom_range(0, 20), v);
                end
                else
                    random_query();
            end
        end

        wait_quiet();
        if (errors == 0)
            $display("tile_map_box_collision: match");
        else
            $display("tile_map_box_collision: mismatch");
        $finish;
    end

    // Watchdog well past the slowest legal run, including the clearing pass
    initial
    begin
        #5000000;
        $display("tile_map_box_collision: mismatch");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+design
design/tmbc_pkg.sv
design/tmbc_ram.sv
design/tmbc_div.sv
design/tile_map_box_collision.sv
tb/sv/tile_map_box_collision_checker.sv
tb/sv/testbench.sv
